[src/hgpc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the preface lookup for the HTTP/2 / gRPC classifier.
// Depends on nothing; used by every module of the block.
package hgpc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 8192;
  localparam int unsigned SCAN_LIMIT_DEF  = 100;

  localparam int unsigned PREFACE_LEN = 24;
  localparam int unsigned HDR_LEN     = 9;
  localparam int unsigned GRPC_MINLEN = 20;
  localparam int unsigned GRPC_TAIL   = 10;
  localparam int unsigned RECENT_LEN  = 3;
  localparam int unsigned EM_W        = 7;

  localparam logic [7:0] TYPE_DATA     = 8'd0;
  localparam logic [7:0] TYPE_HEADERS  = 8'd1;
  localparam logic [7:0] TYPE_SETTINGS = 8'd4;
  localparam logic [7:0] TYPE_PING     = 8'd6;
  localparam logic [7:0] TYPE_MAX      = 8'd9;

  localparam logic [7:0] CHR_G = 8'h67;
  localparam logic [7:0] CHR_R = 8'h72;
  localparam logic [7:0] CHR_P = 8'h70;
  localparam logic [7:0] CHR_C = 8'h63;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_HTTP2   = 2'd1,
    KIND_GRPC    = 2'd2
  } proto_t;

  // "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n", first byte in the lowest bits
  localparam logic [191:0] PREFACE_BYTES = {
    64'h0A0D0A0D4D530A0D, 64'h0A0D302E322F5054, 64'h5448202A20495250
  };

  // Per-cell control, one struct shared by every cell of a chain
  typedef struct packed {
    logic flush;  // treat stored byte as zero (payload starts on this beat)
    logic shift;  // take the neighbor's byte
    logic wipe;   // clear after the beat (payload closes)
  } cell_ctrl_t;

  function automatic logic [7:0] preface_byte(input logic [4:0] k);
    logic [7:0] r;
    r = 8'h00;
    if (k < 5'(PREFACE_LEN)) begin
      r = PREFACE_BYTES[{k, 3'b000} +: 8];
    end
    return r;
  endfunction

endpackage

[src/hgpc_byte_cell.sv]
`timescale 1ns / 1ps
// One byte cell of a shift chain: holds a byte and hands it to its neighbor.
// Depends on hgpc_pkg for the cell control struct.
module hgpc_byte_cell
  import hgpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] din,
  output logic [7:0] tap,
  output logic [7:0] nxt
);

  logic [7:0] q;

  assign tap = ctrl.flush ? 8'h00 : q;
  assign nxt = ctrl.shift ? din : tap;

  always_ff @(posedge clk) begin
    if (rst || ctrl.wipe) begin
      q <= 8'h00;
    end else begin
      q <= nxt;
    end
  end

endmodule

[src/http2_grpc_payload_classifier.sv]
`timescale 1ns / 1ps
// Top level of the HTTP/2 / gRPC payload classifier.
// Depends on hgpc_pkg and hgpc_byte_cell.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------------
//  s_axis   | in  | tvalid/tready        | tdata=payload_byte, tlast=last_byte,
//           |     |                      | tuser=first_byte, conn_http2_seen
//  m_axis   | out | tvalid/tready        | tdata=protocol, conn_http2_now
//
// Takes one byte every cycle unless the output stalls it. The result of a payload
// shows on m_axis in the cycle after its last beat is taken; the byte cells and
// counters update every beat, so throughput is one beat per clock when not stalled.
// rst is synchronous, active high, and empties the payload state and the output.
// A held result stalls the input only while m_axis_tready is low and the output
// register is full.
module http2_grpc_payload_classifier
  import hgpc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int unsigned SCAN_LIMIT  = SCAN_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
  input  logic       s_axis_tlast,   // last_byte
  input  logic [1:0] s_axis_tuser,   // [0] first_byte, [1] conn_http2_seen
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] protocol, [2] conn_http2_now, [7:3] zero
);

  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

  // Beat handshake
  logic acc;
  logic first, last, seen_in;
  logic [7:0] b;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign first         = s_axis_tuser[0];
  assign seen_in       = s_axis_tuser[1];
  assign last          = s_axis_tlast;

  // Payload state
  logic [POS_W-1:0] pos, pos_eff, pos_next;
  logic             pre_ok, pre_eff, pre_next;
  logic             mf, mf_eff, mf_next;
  logic [EM_W-1:0]  em, em_eff, em_next;
  logic             seen, seen_eff;
  logic [31:0]      p32, len32, idx32;
  logic             take;

  assign pos_eff  = first ? '0 : pos;
  assign pre_eff  = first ? 1'b1 : pre_ok;
  assign mf_eff   = first ? 1'b0 : mf;
  assign em_eff   = first ? '0 : em;
  assign seen_eff = first ? seen_in : seen;
  assign p32      = 32'(pos_eff);
  assign take     = p32 < 32'(MAX_PAYLOAD);
  assign pos_next = take ? pos_eff + POS_W'(1) : pos_eff;
  assign len32    = 32'(pos_next);

  // Header chain: after nine shifts cell k holds payload byte 8-k
  cell_ctrl_t hdr_ctrl, rec_ctrl;
  logic [7:0] hdr_tap [HDR_LEN];
  logic [7:0] hdr_nxt [HDR_LEN];
  logic [7:0] rec_tap [RECENT_LEN];
  logic [7:0] rec_nxt [RECENT_LEN];

  assign hdr_ctrl.flush = acc && first;
  assign hdr_ctrl.shift = acc && take && (p32 < 32'(HDR_LEN));
  assign hdr_ctrl.wipe  = acc && last;
  assign rec_ctrl.flush = acc && first;
  assign rec_ctrl.shift = acc && take;
  assign rec_ctrl.wipe  = acc && last;

  for (genvar g = 0; g < HDR_LEN; g++) begin : g_hdr
    hgpc_byte_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (hdr_ctrl),
      .din  ((g == 0) ? b : hdr_tap[(g == 0) ? 0 : g - 1]),
      .tap  (hdr_tap[g]),
      .nxt  (hdr_nxt[g])
    );
  end

  // Recent-byte chain: cell 0 newest
  for (genvar g = 0; g < RECENT_LEN; g++) begin : g_rec
    hgpc_byte_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (rec_ctrl),
      .din  ((g == 0) ? b : rec_tap[(g == 0) ? 0 : g - 1]),
      .tap  (rec_tap[g]),
      .nxt  (rec_nxt[g])
    );
  end

  // Preface check on the first 24 bytes
  always_comb begin
    pre_next = pre_eff;
    if (take && (p32 < 32'(PREFACE_LEN)) && (b != preface_byte(pos_eff[4:0]))) begin
      pre_next = 1'b0;
    end
  end

  // "grpc" scan: 'c' now, "grp" in the three previous bytes
  logic hit;

  assign idx32 = p32 - 32'd3;
  assign hit   = take && (p32 >= 32'd3) && (rec_tap[2] == CHR_G) &&
                 (rec_tap[1] == CHR_R) && (rec_tap[0] == CHR_P) && (b == CHR_C) &&
                 (idx32 >= 32'(HDR_LEN)) && (idx32 < 32'(SCAN_LIMIT)) && !mf_eff;
  assign mf_next = mf_eff || hit;
  assign em_next = hit ? idx32[EM_W-1:0] : em_eff;

  // Classification from the state as it stands after this beat
  logic [7:0]  ftype;
  logic [30:0] stream;
  logic        valid, grpc, preface, now;
  proto_t      proto;

  assign ftype  = hdr_nxt[5];
  assign stream = {hdr_nxt[3][6:0], hdr_nxt[2], hdr_nxt[1], hdr_nxt[0]};

  always_comb begin
    valid = (len32 >= 32'(HDR_LEN)) && (ftype <= TYPE_MAX);
    if (((ftype == TYPE_SETTINGS) || (ftype == TYPE_PING)) && (stream != '0)) begin
      valid = 1'b0;
    end
    if (((ftype == TYPE_DATA) || (ftype == TYPE_HEADERS)) && (stream == '0)) begin
      valid = 1'b0;
    end
    grpc    = valid && (ftype == TYPE_HEADERS) && (len32 > 32'(GRPC_MINLEN)) &&
              mf_next && (32'(em_next) < (len32 - 32'(GRPC_TAIL)));
    preface = pre_next && (len32 >= 32'(PREFACE_LEN));
    now     = seen_eff || preface || valid;
    if (grpc) begin
      proto = KIND_GRPC;
    end else if (valid || preface) begin
      proto = KIND_HTTP2;
    end else begin
      proto = KIND_UNKNOWN;
    end
  end

  // Hold payload counters; clear them, keeping the connection flag, on a taken last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      pre_ok <= 1'b1;
      mf     <= 1'b0;
      em     <= '0;
      seen   <= 1'b0;
    end else if (acc) begin
      if (last) begin
        pos    <= '0;
        pre_ok <= 1'b1;
        mf     <= 1'b0;
        em     <= '0;
        seen   <= now;
      end else begin
        pos    <= pos_next;
        pre_ok <= pre_next;
        mf     <= mf_next;
        em     <= em_next;
        seen   <= seen_eff;
      end
    end
  end

  // Output register: load on a last beat, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (acc && last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last) begin
      m_axis_tdata <= {5'b00000, now, proto};
    end
  end

endmodule

[src/hgpc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the HTTP/2 / gRPC classifier, bound to its top level.
// Depends on hgpc_pkg for the protocol codes.
module hgpc_checker
  import hgpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A full, stalled output blocks the input
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output full");

  // Every taken last beat yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("missing result after last beat");

  // Legal code; any known protocol marks the connection as HTTP/2
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:3] == 5'd0) &&
                      ((m_axis_tdata[1:0] == KIND_UNKNOWN) || m_axis_tdata[2]))
    else $error("bad result code");

endmodule

bind http2_grpc_payload_classifier hgpc_checker u_hgpc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/http2_grpc_payload_classifier_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP/2 / gRPC payload classifier.
// Depends on hgpc_pkg and http2_grpc_payload_classifier; nothing else.
module http2_grpc_payload_classifier_tb;
  import hgpc_pkg::*;

  // Byte limit of the block under test, kept small so runs past it stay short
  localparam int unsigned TB_MAX_PAYLOAD = 128;

  // One classification outcome as it should show on m_axis_tdata
  typedef struct packed {
    proto_t protocol;
    logic   conn_now;
  } verdict_t;

  // Tracks the payload the block is parsing and queues the verdict of each
  // closed payload; results coming out of the block are checked in order.
  class payload_scoreboard;
    logic [13:0] byte_count;
    bit          preface_match;
    logic [7:0]  hdr [9];
    logic [23:0] tail3;
    bit          grpc_seen;
    logic [6:0]  grpc_first;
    bit          conn_seen;
    verdict_t    pending[$];
    int unsigned beats, results, errors;
    int unsigned grpc_count, http2_count, saturated;

    function new();
      clear_payload();
      conn_seen = 0;
      beats = 0;
      results = 0;
      errors = 0;
      grpc_count = 0;
      http2_count = 0;
      saturated = 0;
    endfunction

    function void clear_payload();
      byte_count = '0;
      preface_match = 1;
      foreach (hdr[k]) hdr[k] = 8'h00;
      tail3 = '0;
      grpc_seen = 0;
      grpc_first = '0;
    endfunction

    // Absorb one accepted input beat; predict a verdict when it closes a payload.
    function void note_beat(logic [7:0] b, bit first, bit last, bit seen_in);
      int          off;
      int          len;
      logic [7:0]  ftype;
      logic [30:0] stream;
      bit          valid, grpc, preface;
      verdict_t    v;
      beats++;
      if (first) begin
        clear_payload();
        conn_seen = seen_in;
      end
      // Bytes past the limit are dropped, but the marks still act
      if (int'(byte_count) < TB_MAX_PAYLOAD) begin
        if (int'(byte_count) < PREFACE_LEN &&
            b != PREFACE_BYTES[{byte_count[4:0], 3'b000} +: 8]) begin
          preface_match = 0;
        end
        if (int'(byte_count) < HDR_LEN) hdr[byte_count] = b;
        off = int'(byte_count) - 3;
        if (off >= 0 && tail3 == {CHR_G, CHR_R, CHR_P} && b == CHR_C && !grpc_seen &&
            off >= HDR_LEN && off < SCAN_LIMIT_DEF) begin
          grpc_seen = 1;
          grpc_first = 7'(off);
        end
        tail3 = {tail3[15:0], b};
        byte_count = byte_count + 14'd1;
      end
      if (!last) return;

      len = int'(byte_count);
      if (len == TB_MAX_PAYLOAD) saturated++;
      ftype = hdr[3];
      stream = {hdr[5][6:0], hdr[6], hdr[7], hdr[8]};
      valid = len >= HDR_LEN && ftype <= TYPE_MAX;
      if ((ftype == TYPE_SETTINGS || ftype == TYPE_PING) && stream != '0) valid = 0;
      if ((ftype == TYPE_DATA || ftype == TYPE_HEADERS) && stream == '0) valid = 0;
      grpc = valid && ftype == TYPE_HEADERS && len > GRPC_MINLEN && grpc_seen &&
             int'(grpc_first) < len - GRPC_TAIL;
      preface = preface_match && len >= PREFACE_LEN;
      v.conn_now = conn_seen || preface || valid;
      if (grpc) begin
        v.protocol = KIND_GRPC;
        grpc_count++;
      end else if (valid || preface) begin
        v.protocol = KIND_HTTP2;
        http2_count++;
      end else begin
        v.protocol = KIND_UNKNOWN;
      end
      pending.push_back(v);
      clear_payload();
      conn_seen = v.conn_now;
    endfunction

    // Compare one result beat with the oldest predicted verdict.
    function void check_result(logic [7:0] data);
      verdict_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result 0x%02h arrived with nothing expected", $time, data);
        return;
      end
      want = pending.pop_front();
      results++;
      if (data[1:0] != want.protocol) begin
        errors++;
        $display("%0t: protocol mismatch: expected %0d, actual %0d",
                 $time, want.protocol, data[1:0]);
      end
      if (data[2] != want.conn_now) begin
        errors++;
        $display("%0t: conn_http2_now mismatch: expected %0b, actual %0b",
                 $time, want.conn_now, data[2]);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] payload_byte
  logic       s_axis_tlast;   // last_byte
  logic [1:0] s_axis_tuser;   // [0] first_byte, [1] conn_http2_seen
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [1:0] protocol, [2] conn_http2_now, [7:3] zero

  payload_scoreboard sb;
  logic [7:0]        frame_buf[$];   // payload under construction
  int                sender_idle_pct;
  int unsigned       payload_count;

  http2_grpc_payload_classifier #(
    .MAX_PAYLOAD (TB_MAX_PAYLOAD),
    .SCAN_LIMIT  (SCAN_LIMIT_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample both handshakes at the rising edge; note inputs before checking
  // results so a beat and a result on one edge are never misordered.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_beat(s_axis_tdata, s_axis_tuser[0], s_axis_tlast, s_axis_tuser[1]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Result side: alternate windows with and without backpressure; inside a
  // stall window most stalls are short, a few are long.
  initial begin
    int stall_left;
    int window_left;
    bit stall_on;
    m_axis_tready = 1'b1;
    stall_left = 0;
    window_left = 0;
    stall_on = 1;
    forever begin
      @(negedge clk);
      if (window_left == 0) begin
        stall_on = $urandom_range(0, 3) != 0;
        window_left = $urandom_range(50, 400);
      end
      window_left--;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Drive one beat at the falling edge, hold it until taken, return at the
  // next falling edge with tvalid still high so back-to-back beats need no gap.
  task automatic send_beat(input logic [7:0] b, input bit first, input bit last,
                           input bit seen);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    s_axis_tuser = {seen, first};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stream frame_buf out; the seen flag only matters on the opening beat, so
  // the other beats carry a random value there.
  task automatic send_frame(input bit seen, input bit with_first, input bit with_last);
    int n;
    n = frame_buf.size();
    for (int k = 0; k < n; k++) begin
      send_beat(frame_buf[k], with_first && k == 0, with_last && k == n - 1,
                (k == 0) ? seen : bit'($urandom_range(0, 1)));
    end
    payload_count++;
  endtask

  // Drop tvalid and hold the sender until every predicted verdict has come out.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Frame header (length, type, flags, stream), random body, and optionally
  // "grpc" planted at byte offset grpc_at. Short totals cut the header.
  function automatic void build_frame(int ftype, logic [31:0] stream, int total, int grpc_at);
    logic [23:0] flen;
    flen = 24'(total - HDR_LEN);
    frame_buf.delete();
    frame_buf.push_back(flen[23:16]);
    frame_buf.push_back(flen[15:8]);
    frame_buf.push_back(flen[7:0]);
    frame_buf.push_back(8'(ftype));
    frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(stream[31:24]);
    frame_buf.push_back(stream[23:16]);
    frame_buf.push_back(stream[15:8]);
    frame_buf.push_back(stream[7:0]);
    while (frame_buf.size() < total) frame_buf.push_back(8'($urandom_range(0, 255)));
    while (frame_buf.size() > total) void'(frame_buf.pop_back());
    if (grpc_at >= 0) begin
      frame_buf[grpc_at]     = CHR_G;
      frame_buf[grpc_at + 1] = CHR_R;
      frame_buf[grpc_at + 2] = CHR_P;
      frame_buf[grpc_at + 3] = CHR_C;
    end
  endfunction

  // Connection preface, random tail, one flipped bit at corrupt_at if >= 0.
  function automatic void build_preface(int extra, int corrupt_at);
    frame_buf.delete();
    for (int k = 0; k < PREFACE_LEN; k++) frame_buf.push_back(PREFACE_BYTES[k * 8 +: 8]);
    repeat (extra) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (corrupt_at >= 0) frame_buf[corrupt_at] ^= 8'h01 << $urandom_range(0, 7);
  endfunction

  // Stream id that obeys (legal) or breaks the rule for the frame type.
  function automatic logic [31:0] stream_for(int ftype, bit legal);
    logic [31:0] s;
    s = $urandom();
    if (ftype == TYPE_SETTINGS || ftype == TYPE_PING) begin
      if (legal) s = {s[31], 31'd0};
      else if (s[30:0] == '0) s[0] = 1'b1;
    end else if (ftype == TYPE_DATA || ftype == TYPE_HEADERS) begin
      if (!legal) s = {s[31], 31'd0};
      else if (s[30:0] == '0) s[3] = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      s = 32'd0;
    end
    return s;
  endfunction

  initial begin
    int unsigned rnd_beats0, rnd_results0, rnd_payloads;
    int kind, ftype, total, gpos, hi;
    bit seen;

    sb = new();
    payload_count = 0;
    sender_idle_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    s_axis_tuser = 2'b00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: preface exact, with a tail, broken on its final byte, one short
    build_preface(0, -1);
    send_frame(0, 1, 1);
    build_preface(3, -1);
    send_frame(0, 1, 1);
    build_preface(0, 23);
    send_frame(0, 1, 1);
    build_preface(0, -1);
    void'(frame_buf.pop_back());
    send_frame(0, 1, 1);

    // gRPC window edges: first and last legal offsets, offset vs length - 10,
    // length just above and at the minimum, an offset inside the header
    sender_idle_pct = 20;
    build_frame(TYPE_HEADERS, 32'h7FFF_FFFF, 30, 19);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'd1, 30, 20);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'd3, 21, 9);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'd3, 20, 9);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'd5, 110, 99);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'd5, 104, 100);
    send_frame(0, 1, 1);
    build_frame(TYPE_HEADERS, 32'h100, 21, 8);
    send_frame(0, 1, 1);
    // Reserved stream bit alone leaves stream zero
    build_frame(TYPE_HEADERS, 32'h8000_0000, 21, 9);
    send_frame(0, 1, 1);

    // Stream rules per frame type, type bounds, the nine-byte minimum
    build_frame(TYPE_DATA, 32'd0, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_DATA, 32'd5, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_SETTINGS, 32'd0, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_SETTINGS, 32'd3, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_PING, 32'd0, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_PING, 32'd1, 10, -1);
    send_frame(0, 1, 1);
    build_frame(TYPE_MAX, 32'hFFFF_FFFF, 10, -1);
    send_frame(0, 1, 1);
    build_frame(10, 32'd1, 10, -1);
    send_frame(0, 1, 1);
    build_frame(255, 32'd1, 10, -1);
    send_frame(0, 1, 1);
    build_frame(2, 32'd1, 8, -1);
    send_frame(0, 1, 1);
    build_frame(2, 32'd1, 9, -1);
    send_frame(0, 1, 1);

    // One-byte payloads, each followed by a payload with no first mark, which
    // inherits the flag of the verdict just before it
    frame_buf = '{8'hFF};
    send_frame(1, 1, 1);
    build_frame(TYPE_HEADERS, 32'd1, 21, 9);
    send_frame(0, 0, 1);
    frame_buf = '{8'h00};
    send_frame(0, 1, 1);
    frame_buf = '{8'hA5, 8'h5A, 8'h3C};
    send_frame(1, 0, 1);

    // A payload cut off by a fresh first mark
    build_frame(TYPE_SETTINGS, 32'd0, 12, -1);
    send_frame(0, 1, 0);
    build_frame(TYPE_DATA, 32'd0, 12, -1);
    send_frame(1, 1, 1);

    // Run past the byte limit; the tail bytes must not count
    sender_idle_pct = 0;
    build_frame(TYPE_HEADERS, 32'd7, TB_MAX_PAYLOAD + 8, 40);
    send_frame(0, 1, 1);

    drain_results();

    // Random: mostly well-formed frames with random content, plus preface
    // variants, noise and broken marks
    rnd_beats0 = sb.beats;
    rnd_results0 = sb.pending.size() + sb.results;
    rnd_payloads = 0;
    while (sb.beats - rnd_beats0 < 150 ||
           sb.pending.size() + sb.results - rnd_results0 < 8) begin
      case ($urandom_range(0, 3))
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 5;
        2: sender_idle_pct = 25;
        default: sender_idle_pct = 50;
      endcase
      seen = $urandom_range(0, 3) == 0;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        ftype = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 255) : $urandom_range(0, 9);
        case ($urandom_range(0, 19))
          0: total = $urandom_range(1, 8);
          1, 2: total = $urandom_range(41, 130);
          default: total = $urandom_range(9, 40);
        endcase
        gpos = -1;
        if (ftype == TYPE_HEADERS && total >= 13 && $urandom_range(0, 9) < 7) begin
          hi = (total - 4 < 104) ? total - 4 : 104;
          gpos = $urandom_range(9, hi);
        end
        build_frame(ftype, stream_for(ftype, $urandom_range(0, 4) != 0), total, gpos);
        send_frame(seen, 1, 1);
      end else if (kind < 75) begin
        build_preface($urandom_range(0, 20),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : -1);
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) void'(frame_buf.pop_back());
        send_frame(seen, 1, 1);
      end else if (kind < 90) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom_range(0, 255)));
        send_frame(seen, 1, 1);
      end else begin
        ftype = $urandom_range(0, 9);
        build_frame(ftype, stream_for(ftype, 1), $urandom_range(1, 30), -1);
        send_frame(seen, $urandom_range(0, 1), $urandom_range(0, 1));
      end
      rnd_payloads++;
      // Let the pipeline run dry once in the middle of the random part
      if (rnd_payloads == 4) drain_results();
    end
    s_axis_tvalid = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d payloads in %0d beats, %0d of them over the byte limit.",
             payload_count, sb.beats, sb.saturated);
    $display("Checked %0d verdicts: %0d gRPC, %0d HTTP/2, the rest unknown; %0d errors.",
             sb.results, sb.grpc_count, sb.http2_count, sb.errors);
    if (sb.errors == 0) begin
      $display("http2_grpc_payload_classifier_tb passed");
    end else begin
      $display("http2_grpc_payload_classifier_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("http2_grpc_payload_classifier_tb failed");
    $finish;
  end

endmodule
